/* src/assert_macros.svh */
// Assertion macros shared by the ADC window accumulator RTL.
// Bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/awm_pkg.sv */
// Package for the ADC window accumulator: field widths, channel codes,
// register map and the types passed between modules. No dependencies.
`timescale 1ns / 1ps

package awm_pkg;

    localparam int CH_W  = 2;
    localparam int SUM_W = 23;
    localparam int SQ_W  = 31;
    localparam int WL_W  = 13;
    localparam int APB_W = 32;

    localparam logic [WL_W-1:0] WL_RESET = 13'd521;

    localparam logic [CH_W-1:0] CH_AC      = 2'd0;
    localparam logic [CH_W-1:0] CH_VFB     = 2'd1;
    localparam logic [CH_W-1:0] CH_IFB     = 2'd2;
    localparam logic [CH_W-1:0] CH_IGNORED = 2'd3;

    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic              psel;
        logic              penable;
        logic              pwrite;
        logic              reg_index;
        logic [APB_W-1:0]  pwdata;
    } t_apb_req;

    typedef struct packed {
        logic                    emit;
        logic [CH_W-1:0]         channel;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sum_sq;
    } t_acc_res;

endpackage

/* src/adc_window_mean_rms_accumulator.sv */
// Windowed sum and sum-of-squares accumulator for a tagged ADC sample stream.
// Top level: input register, accumulator core, result register, APB port; uses awm_pkg.
// Each transfer on the s_ side is registered, then added to its channel's totals
// once the result register is free or being taken; a finished window loads the
// result register, which drives the m_ side. One sample is taken every cycle;
// the rate is set by the single accumulate step per channel, and the input
// stalls only while both the input register and an untaken result are held.
// Channel 3 is dropped; channel 0 is centred by mid-scale and also squared.
// window_length sits at byte address 0 and is clamped to 1..MAX_WINDOW.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adc_window_mean_rms_accumulator #(
    parameter int SAMPLE_BITS = 10,
    parameter int MAX_WINDOW  = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [SAMPLE_BITS-1:0] sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // [1:0] channel
    input  logic [awm_pkg::CH_W-1:0]               s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [22:0] window_sum, [53:23] window_sum_squares
    output logic [55:0]                            m_tdata,
    // [1:0] result_channel
    output logic [awm_pkg::CH_W-1:0]               m_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [awm_pkg::APB_W-1:0]              pwdata,
    output logic [awm_pkg::APB_W-1:0]              prdata,
    output logic                                   pready
);
    import awm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > WL_W) ? CNT_W : WL_W;

    logic                    r_in_valid;
    logic [SAMPLE_BITS-1:0]  r_in_sample;
    logic [CH_W-1:0]         r_in_channel;
    logic                    r_out_valid;
    logic [CH_W-1:0]         r_out_channel;
    logic signed [SUM_W-1:0] r_out_sum;
    logic [SQ_W-1:0]         r_out_sum_sq;

    logic                    advance;
    logic                    s_xfer;
    logic [CMP_W-1:0]        window;
    t_apb_req                apb_req;
    t_acc_res                acc_res;

    assign apb_req.psel      = psel;
    assign apb_req.penable   = penable;
    assign apb_req.pwrite    = pwrite;
    assign apb_req.reg_index = paddr[2];
    assign apb_req.pwdata    = pwdata;
    assign pready            = 1'b1;

    awm_cfg #(
        .MAX_WINDOW (MAX_WINDOW),
        .CMP_W      (CMP_W)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (apb_req),
        .o_prdata (prdata),
        .o_window (window)
    );

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;
    assign s_xfer   = s_tvalid && s_tready;

    awm_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW),
        .CMP_W       (CMP_W)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_sample  (r_in_sample),
        .i_channel (r_in_channel),
        .i_window  (window),
        .o_res     (acc_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && acc_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_sample  <= s_tdata[SAMPLE_BITS-1:0];
            r_in_channel <= s_tuser;
        end
        if (advance && acc_res.emit) begin
            r_out_channel <= acc_res.channel;
            r_out_sum     <= acc_res.sum;
            r_out_sum_sq  <= acc_res.sum_sq;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_channel;
    assign m_tdata  = {2'b00, r_out_sum_sq, r_out_sum};

    `AWM_ASSERT_IMP(a_no_ignored_result, i_clk, i_rst_n, r_out_valid, r_out_channel != CH_IGNORED)
    `AWM_ASSERT_IMP(a_sq_only_ac, i_clk, i_rst_n, r_out_valid && r_out_channel != CH_AC, r_out_sum_sq == '0)
    `AWM_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_tready, r_in_valid && r_out_valid && !m_tready)
    `AWM_ASSERT_NXT(a_hold_input, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)

endmodule

/* src/awm_cfg.sv */
// Configuration register bank for the ADC window accumulator.
// Holds window_length and derives the clamped window; depends on awm_pkg.
`timescale 1ns / 1ps

module awm_cfg #(
    parameter int MAX_WINDOW = 4096,
    parameter int CMP_W      = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  awm_pkg::t_apb_req         i_req,
    output logic [awm_pkg::APB_W-1:0] o_prdata,
    output logic [CMP_W-1:0]          o_window
);
    import awm_pkg::*;

    logic [WL_W-1:0]  r_window_length;
    logic [CMP_W-1:0] wl_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_RESET;
        end else if (i_req.psel && i_req.penable && i_req.pwrite
                     && i_req.reg_index == REG_WINDOW_LENGTH) begin
            r_window_length <= i_req.pwdata[WL_W-1:0];
        end
    end

    always_comb begin
        wl_ext = CMP_W'(r_window_length);
        if (wl_ext == '0) begin
            o_window = CMP_W'(1);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            o_window = CMP_W'(MAX_WINDOW);
        end else begin
            o_window = wl_ext;
        end
    end

    assign o_prdata = (i_req.reg_index == REG_WINDOW_LENGTH) ?
                      APB_W'(r_window_length) : '0;

endmodule

/* src/awm_accum.sv */
// Per-channel accumulators: counts, sums and the AC sum of squares.
// Updates state for one sample per step and reports a finished window; uses awm_pkg.
`timescale 1ns / 1ps

module awm_accum #(
    parameter int SAMPLE_BITS = 10,
    parameter int MAX_WINDOW  = 4096,
    parameter int CMP_W       = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic [awm_pkg::CH_W-1:0]    i_channel,
    input  logic [CMP_W-1:0]            i_window,
    output awm_pkg::t_acc_res           o_res
);
    import awm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int C_W    = SAMPLE_BITS + 1;
    localparam int PROD_W = 2 * C_W;
    localparam int MUL_W  = (PROD_W > SQ_W) ? PROD_W : SQ_W;
    localparam logic [C_W-1:0] OFFSET = C_W'(((2 ** SAMPLE_BITS) - 1) / 2);

    logic [CNT_W-1:0]        r_cnt [3];
    logic signed [SUM_W-1:0] r_sum [3];
    logic [SQ_W-1:0]         r_sum_sq;

    logic                    ch_ok;
    logic [CNT_W-1:0]        cnt_cur;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0] sum_cur;
    logic signed [SUM_W-1:0] sum_add;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [C_W-1:0]   centred;
    logic signed [MUL_W-1:0] c_ext;
    logic [MUL_W-1:0]        prod;
    logic [SQ_W-1:0]         sq_new;
    logic                    emit;

    always_comb begin
        ch_ok   = 1'b1;
        cnt_cur = r_cnt[0];
        sum_cur = r_sum[0];
        case (i_channel)
            CH_AC: begin
                cnt_cur = r_cnt[0];
                sum_cur = r_sum[0];
            end
            CH_VFB: begin
                cnt_cur = r_cnt[1];
                sum_cur = r_sum[1];
            end
            CH_IFB: begin
                cnt_cur = r_cnt[2];
                sum_cur = r_sum[2];
            end
            default: begin
                ch_ok = 1'b0;
            end
        endcase

        centred = $signed(C_W'(i_sample)) - $signed(OFFSET);
        c_ext   = MUL_W'(centred);
        prod    = $unsigned(c_ext * c_ext);
        sq_new  = r_sum_sq + prod[SQ_W-1:0];

        sum_add = (i_channel == CH_AC) ? SUM_W'(centred) : $signed(SUM_W'(i_sample));
        sum_new = sum_cur + sum_add;
        cnt_inc = cnt_cur + CNT_W'(1);
        emit    = ch_ok && (CMP_W'(cnt_inc) >= i_window);

        o_res.emit    = emit;
        o_res.channel = i_channel;
        o_res.sum     = sum_new;
        o_res.sum_sq  = (i_channel == CH_AC) ? sq_new : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cnt[k] <= '0;
                r_sum[k] <= '0;
            end
            r_sum_sq <= '0;
        end else if (i_step && ch_ok) begin
            r_cnt[i_channel] <= emit ? '0 : cnt_inc;
            r_sum[i_channel] <= emit ? '0 : sum_new;
            if (i_channel == CH_AC) begin
                r_sum_sq <= emit ? '0 : sq_new;
            end
        end
    end

endmodule

/* verif/adc_window_totals_checker.sv */
// Checker for the ADC window accumulator: watches the sample, result and APB channels,
// predicts each window's totals and compares them with the results. Uses awm_pkg.
`timescale 1ns / 1ps

module adc_window_totals_checker #(
    parameter int SAMPLE_BITS = 10,
    parameter int MAX_WINDOW  = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // [9:0] sample, [15:10] padding
    input  logic [15:0]               i_s_tdata,
    // [1:0] channel
    input  logic [awm_pkg::CH_W-1:0]  i_s_tuser,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // [22:0] window_sum, [53:23] window_sum_squares, [55:54] padding
    input  logic [55:0]               i_m_tdata,
    // [1:0] result_channel
    input  logic [awm_pkg::CH_W-1:0]  i_m_tuser,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic                      i_pready,
    input  logic [2:0]                i_paddr,
    input  logic [awm_pkg::APB_W-1:0] i_pwdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    import awm_pkg::*;

    localparam logic [2:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 2'b00};
    localparam int MID_SCALE = ((1 << SAMPLE_BITS) - 1) / 2;

    typedef struct packed {
        logic [CH_W-1:0]  chan;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sum_sq;
    } t_window_total;

    t_window_total           expected_totals[$];
    logic [WL_W-1:0]         window_length;
    logic [WL_W-1:0]         sample_count [3];
    logic signed [SUM_W:0]   chan_sum [3];
    logic [SQ_W-1:0]         ac_sum_sq;
    int                      mismatches;

    function automatic int unsigned window_limit(input logic [WL_W-1:0] len);
        if (len == '0) return 1;
        if (len > MAX_WINDOW) return MAX_WINDOW;
        return len;
    endfunction

    task automatic accumulate(input logic [SAMPLE_BITS-1:0] smp, input logic [CH_W-1:0] chan);
        int            centred;
        t_window_total done;
        if (chan == CH_IGNORED) return;
        if (chan == CH_AC) begin
            centred = int'(smp) - MID_SCALE;
            chan_sum[chan] = chan_sum[chan] + (SUM_W + 1)'(centred);
            ac_sum_sq = ac_sum_sq + SQ_W'(centred * centred);
        end else begin
            chan_sum[chan] = chan_sum[chan] + (SUM_W + 1)'(smp);
        end
        sample_count[chan] = sample_count[chan] + 1'b1;
        if (sample_count[chan] >= window_limit(window_length)) begin
            done.chan   = chan;
            done.sum    = chan_sum[chan][SUM_W-1:0];
            done.sum_sq = (chan == CH_AC) ? ac_sum_sq : '0;
            expected_totals.push_back(done);
            sample_count[chan] = '0;
            chan_sum[chan] = '0;
            if (chan == CH_AC) ac_sum_sq = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_window_total want;
        if (!i_rst_n) begin
            window_length = WL_RESET;
            for (int k = 0; k < 3; k++) begin
                sample_count[k] = '0;
                chan_sum[k] = '0;
            end
            ac_sum_sq = '0;
            expected_totals.delete();
            mismatches = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == WINDOW_ADDR) begin
                window_length = i_pwdata[WL_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                accumulate(i_s_tdata[SAMPLE_BITS-1:0], i_s_tuser);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_totals.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: chan %0d data %h", i_m_tuser, i_m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = expected_totals.pop_front();
                    if (i_m_tuser !== want.chan || i_m_tdata[22:0] !== want.sum ||
                        i_m_tdata[53:23] !== want.sum_sq || i_m_tdata[55:54] !== 2'b00) begin
                        if (mismatches < 10) begin
                            $display("result mismatch: exp chan %0d sum %h sq %h,",
                                     want.chan, want.sum, want.sum_sq,
                                     " got chan %0d sum %h sq %h pad %b",
                                     i_m_tuser, i_m_tdata[22:0], i_m_tdata[53:23],
                                     i_m_tdata[55:54]);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_totals.size();
        o_fail_count <= mismatches;
    end

endmodule

/* verif/adc_window_mean_rms_accumulator_tb.sv */
// Testbench top for the ADC window accumulator: clock, reset, sample and APB stimulus,
// random output stalls and the verdict. Depends on awm_pkg and adc_window_totals_checker.
`timescale 1ns / 1ps

module adc_window_mean_rms_accumulator_tb;
    import awm_pkg::*;

    localparam int MAX_CYCLES  = 2_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 139;
    localparam int MAX_WINDOW_SAT = 4096;
    localparam logic [2:0] WINDOW_ADDR   = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // [9:0] sample, [15:10] padding
    logic [15:0]       s_tdata;
    // [1:0] channel
    logic [CH_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    // [22:0] window_sum, [53:23] window_sum_squares, [55:54] padding
    logic [55:0]       m_tdata;
    // [1:0] result_channel
    logic [CH_W-1:0]   m_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                burst_left;

    adc_window_mean_rms_accumulator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    adc_window_totals_checker totals_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= MAX_CYCLES) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Output stalls: mostly short, a few long, with stretches of steady ready.
    initial begin
        int stall;
        int steady;
        int r;
        stall = 0;
        steady = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (steady > 0) begin
                steady--;
                m_tready <= 1'b1;
            end else begin
                if (stall == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 2) steady = $urandom_range(50, 300);
                    else if (r < 5) stall = $urandom_range(10, 40);
                    else if (r < 35) stall = $urandom_range(1, 3);
                end
                if (stall > 0) begin
                    stall--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return $urandom_range(10, 40);
        if (r < 35) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [9:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 10'd0;
        if (r < 24) return 10'h3FF;
        if (r < 32) return 10'd511;
        if (r < 40) return 10'd512;
        return 10'($urandom);
    endfunction

    function automatic logic [CH_W-1:0] random_channel();
        if ($urandom_range(0, 99) < 8) return CH_IGNORED;
        return CH_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [WL_W-1:0] phase_window(input int phase);
        case (phase)
            0: return 13'd1;
            1: return 13'd2;
            2: return 13'd0;
            3: return 13'd3;
            4: return 13'($urandom_range(4, 12));
            5: return 13'($urandom_range(MAX_WINDOW_SAT + 1, 8191));
            6: return 13'($urandom_range(13, 40));
            default: return 13'd5;
        endcase
    endfunction

    // Hold the transfer until accepted; leave tvalid high when no gap follows.
    task automatic send_sample(input logic [9:0] smp, input logic [CH_W-1:0] chan);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'($urandom), smp};
        s_tuser  <= chan;
        do @(posedge i_clk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 99) == 0) burst_left = $urandom_range(30, 120);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_window(input logic [WL_W-1:0] len);
        write_reg(WINDOW_ADDR, {19'($urandom), len});
    endtask

    initial begin
        int n;
        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        burst_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes with one result per sample on channels 0-2; the unmapped write is dropped.
        set_window(13'd1);
        write_reg(UNMAPPED_ADDR, 32'h0000_0007);
        send_sample(10'd0, CH_AC);
        send_sample(10'h3FF, CH_AC);
        send_sample(10'd511, CH_AC);
        send_sample(10'd512, CH_AC);
        send_sample(10'd0, CH_VFB);
        send_sample(10'h3FF, CH_VFB);
        send_sample(10'd0, CH_IFB);
        send_sample(10'h3FF, CH_IFB);
        send_sample(10'h3FF, CH_IGNORED);
        send_sample(10'd0, CH_IGNORED);

        // Zero length acts as one.
        wait_drained();
        set_window(13'd0);
        send_sample(10'd510, CH_AC);
        send_sample(10'd5, CH_IFB);
        send_sample(10'd700, CH_VFB);

        // Oversized length saturates; counts build up on channels 0-2 without a result.
        wait_drained();
        set_window(13'h1FFF);
        repeat (10) send_sample(10'($urandom), CH_IFB);
        repeat (3) send_sample(10'($urandom), CH_VFB);
        repeat (12) send_sample(10'h3FF, CH_AC);
        send_sample(10'($urandom), CH_IGNORED);

        // Shorten below the IFB and AC counts already held.
        wait_drained();
        set_window(13'd4);
        send_sample(10'd77, CH_IFB);
        send_sample(10'd5, CH_VFB);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            set_window(phase_window(phase));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) wait_drained();
                send_sample(random_sample(), random_channel());
            end
        end

        s_tvalid <= 1'b0;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending != 0 && n < 20000);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
